### rtl/core/fcsg_pkg.sv
// fcsg_pkg: shared types and constants of the filled circle span generator
// no dependencies; used by the interfaces and every module in rtl/core

package fcsg_pkg;

  localparam int unsigned COORD_W   = 14;
  localparam int unsigned SPAN_W    = 15;
  localparam int unsigned DIAM_W    = 7;
  localparam int unsigned CLIP_W    = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned RAD_W     = 6;
  localparam int unsigned DEC_W     = 12;
  localparam int unsigned CMP_W     = 16;

  localparam int unsigned MAX_DIAMETER_DEF = 120;

  localparam logic [CFG_IDX_W-1:0] REG_BOUND_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_BOTTOM = 2'd3;

  localparam logic [CLIP_W-1:0] CLIP_LO_RESET = 12'd0;
  localparam logic [CLIP_W-1:0] CLIP_HI_RESET = 12'd4095;

  localparam logic signed [DEC_W-1:0] DEC_INIT   = 12'sd3;
  localparam logic signed [DEC_W-1:0] DEC_STEP_E = 12'sd6;
  localparam logic signed [DEC_W-1:0] DEC_STEP_D = 12'sd10;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [RAD_W-1:0]          r;
    logic signed [DEC_W-1:0]   p;
  } job_t;

endpackage

### rtl/core/fcsg_if.sv
// fcsg_if: handshake channels of the filled circle span generator
// depends on fcsg_pkg for field widths

interface fcsg_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [fcsg_pkg::CFG_IDX_W-1:0]      index;
  logic [fcsg_pkg::CLIP_W-1:0]         data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface fcsg_circle_if;
  logic                                valid;
  logic                                ready;
  logic signed [fcsg_pkg::COORD_W-1:0] center_x;
  logic signed [fcsg_pkg::COORD_W-1:0] center_y;
  logic [fcsg_pkg::DIAM_W-1:0]         diameter;
  modport source (output valid, center_x, center_y, diameter, input ready);
  modport sink (input valid, center_x, center_y, diameter, output ready);
endinterface

interface fcsg_span_if;
  logic                                valid;
  logic                                ready;
  logic signed [fcsg_pkg::SPAN_W-1:0]  span_left;
  logic signed [fcsg_pkg::SPAN_W-1:0]  span_right;
  logic signed [fcsg_pkg::SPAN_W-1:0]  row_upper;
  logic signed [fcsg_pkg::SPAN_W-1:0]  row_lower;
  logic                                last;
  modport source (output valid, span_left, span_right, row_upper, row_lower, last,
                  input ready);
  modport sink (input valid, span_left, span_right, row_upper, row_lower, last,
                output ready);
endinterface

### rtl/core/fcsg_front.sv
// fcsg_front: clip registers, circle intake, diameter saturation and rejection
// depends on fcsg_pkg and fcsg_if; feeds fcsg_queue with job_t words

module fcsg_front #(
  parameter int unsigned MAX_DIAMETER = fcsg_pkg::MAX_DIAMETER_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  fcsg_cfg_if.sink             cfg,
  fcsg_circle_if.sink          circle,
  output logic                 push_valid,
  input  logic                 push_ready,
  output fcsg_pkg::job_t       push_job
);

  localparam logic [fcsg_pkg::DIAM_W-1:0] DIAM_MAX = fcsg_pkg::DIAM_W'(MAX_DIAMETER);

  logic [fcsg_pkg::CLIP_W-1:0] bound_left;
  logic [fcsg_pkg::CLIP_W-1:0] bound_top;
  logic [fcsg_pkg::CLIP_W-1:0] bound_right;
  logic [fcsg_pkg::CLIP_W-1:0] bound_bottom;

  logic [fcsg_pkg::DIAM_W-1:0]       diam_sat;
  logic [fcsg_pkg::RAD_W-1:0]        rad;
  logic signed [fcsg_pkg::CMP_W-1:0] cx_w;
  logic signed [fcsg_pkg::CMP_W-1:0] cy_w;
  logic signed [fcsg_pkg::CMP_W-1:0] r_w;
  logic                              reject;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bound_left   <= fcsg_pkg::CLIP_LO_RESET;
      bound_top    <= fcsg_pkg::CLIP_LO_RESET;
      bound_right  <= fcsg_pkg::CLIP_HI_RESET;
      bound_bottom <= fcsg_pkg::CLIP_HI_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        fcsg_pkg::REG_BOUND_LEFT:   bound_left   <= cfg.data;
        fcsg_pkg::REG_BOUND_TOP:    bound_top    <= cfg.data;
        fcsg_pkg::REG_BOUND_RIGHT:  bound_right  <= cfg.data;
        fcsg_pkg::REG_BOUND_BOTTOM: bound_bottom <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    diam_sat = (circle.diameter > DIAM_MAX) ? DIAM_MAX : circle.diameter;
    rad      = diam_sat[fcsg_pkg::RAD_W:1];
    cx_w     = {{(fcsg_pkg::CMP_W-fcsg_pkg::COORD_W){circle.center_x[fcsg_pkg::COORD_W-1]}},
                circle.center_x};
    cy_w     = {{(fcsg_pkg::CMP_W-fcsg_pkg::COORD_W){circle.center_y[fcsg_pkg::COORD_W-1]}},
                circle.center_y};
    r_w      = $signed({{(fcsg_pkg::CMP_W-fcsg_pkg::RAD_W){1'b0}}, rad});
    reject   = (cx_w + r_w < $signed({4'b0, bound_left}))  ||
               (cx_w - r_w > $signed({4'b0, bound_right})) ||
               (cy_w + r_w < $signed({4'b0, bound_top}))   ||
               (cy_w - r_w > $signed({4'b0, bound_bottom}));
  end

  assign circle.ready = push_ready;
  assign push_valid   = circle.valid && !reject;

  always_comb begin
    push_job.cx = circle.center_x;
    push_job.cy = circle.center_y;
    push_job.r  = rad;
    push_job.p  = fcsg_pkg::DEC_INIT -
                  $signed({{(fcsg_pkg::DEC_W-fcsg_pkg::DIAM_W){1'b0}}, diam_sat});
  end

endmodule

### rtl/core/fcsg_queue.sv
// fcsg_queue: two-entry job queue between intake and span walker
// depends on fcsg_pkg for job_t

module fcsg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  fcsg_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output fcsg_pkg::job_t pop_job
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  fcsg_pkg::job_t   slot [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != (PTR_W+1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = slot[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/fcsg_back.sv
// fcsg_back: midpoint walker that emits one span pair per cycle unless span.ready stalls
// depends on fcsg_pkg and fcsg_if; takes job_t words from fcsg_queue

module fcsg_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  fcsg_pkg::job_t pop_job,
  fcsg_span_if.source    span
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EAST = 2'd1;
  localparam logic [1:0] ST_DIAG = 2'd2;
  localparam logic [1:0] ST_TAIL = 2'd3;

  localparam int unsigned RW = fcsg_pkg::RAD_W;
  localparam int unsigned SW = fcsg_pkg::SPAN_W;

  logic [1:0]                         state;
  logic [1:0]                         state_next;
  logic signed [fcsg_pkg::COORD_W-1:0] cx;
  logic signed [fcsg_pkg::COORD_W-1:0] cy;
  logic [RW-1:0]                      x;
  logic [RW-1:0]                      y;
  logic signed [fcsg_pkg::DEC_W-1:0]  p;
  logic signed [fcsg_pkg::DEC_W-1:0]  p_next;

  logic                  advance;
  logic                  last_next;
  logic [RW:0]           x_inc;
  logic [RW:0]           y_dec;
  logic [RW-1:0]         col_off;
  logic [RW-1:0]         row_off;
  logic signed [SW-1:0]  cx_w;
  logic signed [SW-1:0]  cy_w;
  logic signed [SW-1:0]  col_w;
  logic signed [SW-1:0]  row_w;
  logic signed [fcsg_pkg::DEC_W-1:0] x4;
  logic signed [fcsg_pkg::DEC_W-1:0] y4;

  assign advance   = (state != ST_IDLE) && (!span.valid || span.ready);
  assign pop_ready = (state == ST_IDLE);

  always_comb begin
    x_inc   = {1'b0, x} + 1'b1;
    y_dec   = {1'b0, y} - 1'b1;
    x4      = $signed({{(fcsg_pkg::DEC_W-RW-2){1'b0}}, x, 2'b00});
    y4      = $signed({{(fcsg_pkg::DEC_W-RW-2){1'b0}}, y, 2'b00});
    col_off = (state == ST_EAST) ? y : x;
    row_off = (state == ST_EAST) ? x : y;
    cx_w    = {{(SW-fcsg_pkg::COORD_W){cx[fcsg_pkg::COORD_W-1]}}, cx};
    cy_w    = {{(SW-fcsg_pkg::COORD_W){cy[fcsg_pkg::COORD_W-1]}}, cy};
    col_w   = $signed({{(SW-RW){1'b0}}, col_off});
    row_w   = $signed({{(SW-RW){1'b0}}, row_off});

    state_next = state;
    p_next     = p;
    last_next  = 1'b0;
    case (state)
      ST_EAST: begin
        if (p < 0) begin
          p_next     = p + x4 + fcsg_pkg::DEC_STEP_E;
          state_next = (x_inc < {1'b0, y}) ? ST_EAST : ST_TAIL;
        end else begin
          state_next = ST_DIAG;
        end
      end
      ST_DIAG: begin
        p_next = p + x4 - y4 + fcsg_pkg::DEC_STEP_D;
        if (x_inc < y_dec) begin
          state_next = ST_EAST;
        end else if (x_inc == y_dec) begin
          state_next = ST_TAIL;
        end else begin
          state_next = ST_IDLE;
          last_next  = 1'b1;
        end
      end
      ST_TAIL: begin
        state_next = ST_IDLE;
        last_next  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (state == ST_IDLE) begin
      if (pop_valid) begin
        state <= (pop_job.r != '0) ? ST_EAST : ST_TAIL;
      end
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      if (pop_valid) begin
        cx <= pop_job.cx;
        cy <= pop_job.cy;
        x  <= '0;
        y  <= pop_job.r;
        p  <= pop_job.p;
      end
    end else if (advance) begin
      p <= p_next;
      if (state == ST_DIAG || (state == ST_EAST && p < 0)) begin
        x <= x_inc[RW-1:0];
      end
      if (state == ST_DIAG) begin
        y <= y_dec[RW-1:0];
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      span.valid <= 1'b0;
    end else if (advance) begin
      span.valid <= 1'b1;
    end else if (span.ready) begin
      span.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      span.span_left  <= cx_w - col_w;
      span.span_right <= cx_w + col_w;
      span.row_upper  <= cy_w - row_w;
      span.row_lower  <= cy_w + row_w;
      span.last       <= last_next;
    end
  end

endmodule

### rtl/core/filled_circle_span_generator.sv
// filled_circle_span_generator: top level of the filled circle span generator
// depends on fcsg_pkg, fcsg_if, fcsg_front, fcsg_queue and fcsg_back
//
//   channel  dir  fields                                              word moves when
//   cfg      in   index, data                                         valid && ready
//   circle   in   center_x, center_y, diameter                        valid && ready
//   span     out  span_left, span_right, row_upper, row_lower, last   valid && ready
//
// an accepted circle enters the queue and is loaded by the walker once the walker is idle,
// then one span pair per cycle unless span.ready stalls, always radius + 1 pairs per circle
// rejected circles are taken at intake and produce no word
// the two-entry queue lets intake go on while the walker stalls on span.ready
// rst is synchronous; it restores the full clip window and empties the queue

module filled_circle_span_generator #(
  parameter int unsigned MAX_DIAMETER = fcsg_pkg::MAX_DIAMETER_DEF
) (
  input  logic        clk,
  input  logic        rst,
  fcsg_cfg_if.sink    cfg,
  fcsg_circle_if.sink circle,
  fcsg_span_if.source span
);

  logic           push_valid;
  logic           push_ready;
  fcsg_pkg::job_t push_job;
  logic           pop_valid;
  logic           pop_ready;
  fcsg_pkg::job_t pop_job;

  fcsg_front #(
    .MAX_DIAMETER(MAX_DIAMETER)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .circle     (circle),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  fcsg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  fcsg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .span      (span)
  );

endmodule
